// File: rtl/ncr_pkg.sv
`default_nettype none

package ncr_pkg;

    localparam int CODE_W  = 16;
    localparam int VALUE_W = 31;
    // accumulator for value * 10 + digit before the range check
    localparam int ACC_W   = VALUE_W + 4;

    localparam logic [CODE_W-1:0] CH_AMP   = 16'h0026;
    localparam logic [CODE_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [CODE_W-1:0] CH_SEMI  = 16'h003B;
    localparam logic [CODE_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CODE_W-1:0] CH_NINE  = 16'h0039;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = {VALUE_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_AMP    = 2'd1,
        MODE_DIGITS = 2'd2,
        MODE_DROP   = 2'd3
    } parse_mode_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              has_char;
        logic              end_of_text;
    } ncr_result_t;

endpackage

`default_nettype wire

// File: rtl/ncr_parser.sv
`default_nettype none

module ncr_parser (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire logic [ncr_pkg::CODE_W-1:0] char_code,
    input  wire logic                      last,
    output ncr_pkg::ncr_result_t           result
);
    import ncr_pkg::*;

    parse_mode_t        mode_reg, mode_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               overflow_reg, overflow_next;

    logic              is_amp;
    logic              is_digit;
    logic [ACC_W-1:0]  acc;
    logic              emit;
    logic [CODE_W-1:0] emit_code;

    assign is_amp   = (char_code == CH_AMP);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

    // value * 10 + digit as two shifted adds
    assign acc = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0}
               + {{(ACC_W-4){1'b0}}, char_code[3:0]};

    always_comb
    begin
        mode_next     = mode_reg;
        value_next    = value_reg;
        overflow_next = overflow_reg;
        if (is_amp)
        begin
            mode_next = MODE_AMP;
        end
        else
        begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    mode_next = MODE_TEXT;
                end
                MODE_AMP:
                begin
                    if (char_code == CH_HASH)
                    begin
                        mode_next     = MODE_DIGITS;
                        value_next    = '0;
                        overflow_next = 1'b0;
                    end
                    else
                    begin
                        mode_next = MODE_DROP;
                    end
                end
                MODE_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (!overflow_reg)
                        begin
                            if (acc > {{(ACC_W-VALUE_W){1'b0}}, VALUE_LIMIT})
                            begin
                                overflow_next = 1'b1;
                                value_next    = VALUE_LIMIT;
                            end
                            else
                            begin
                                value_next = acc[VALUE_W-1:0];
                            end
                        end
                    end
                    else if (char_code == CH_SEMI)
                    begin
                        mode_next = MODE_TEXT;
                    end
                    else
                    begin
                        mode_next = MODE_DROP;
                    end
                end
                MODE_DROP:
                begin
                    mode_next = MODE_DROP;
                end
                default:
                begin
                    mode_next = MODE_TEXT;
                end
            endcase
        end
        // end of text brings everything back to the reset state
        if (last)
        begin
            mode_next     = MODE_TEXT;
            value_next    = '0;
            overflow_next = 1'b0;
        end
    end

    always_comb
    begin
        emit      = 1'b0;
        emit_code = '0;
        if (!is_amp)
        begin
            case (mode_reg)
                MODE_TEXT:
                begin
                    emit      = 1'b1;
                    emit_code = char_code;
                end
                MODE_DIGITS:
                begin
                    if (!is_digit && (char_code == CH_SEMI))
                    begin
                        emit      = 1'b1;
                        emit_code = overflow_reg ? '0 : value_reg[CODE_W-1:0];
                    end
                end
                default:
                begin
                    emit      = 1'b0;
                    emit_code = '0;
                end
            endcase
        end
        result.valid       = step && (emit || last);
        result.code        = emit_code;
        result.has_char    = emit;
        result.end_of_text = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_TEXT;
            value_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            value_reg    <= value_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/numeric_char_reference_decoder.sv
`default_nettype none

// Decodes decimal character references of the form "&#digits;" in a stream of
// 16-bit code units, one code unit per transaction. Plain text before the first
// '&' and after a complete reference passes through; a failed reference drops
// text up to the next '&'. The block takes one code unit every cycle while the
// output is not stalled. A code unit is captured in the input register when it
// is accepted, and its result is loaded into the result register when that
// register is free or emptying; the result is offered from there. The full
// rate is possible because the multiply-by-ten accumulate in the parser is
// short combinational logic between those two registers. A code unit that
// produces nothing gives no output transaction; the last code unit of a text
// always gives one, with end_of_text set.
module numeric_char_reference_decoder (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic [ncr_pkg::CODE_W-1:0] char_code,
    input  wire logic                       last,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      logic [ncr_pkg::CODE_W-1:0] out_code,
    output      logic                       has_char,
    output      logic                       end_of_text
);
    import ncr_pkg::*;

    logic              s1_valid_reg;
    logic [CODE_W-1:0] s1_code_reg;
    logic              s1_last_reg;
    logic              s1_advance;
    logic              in_take;

    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_has_char_reg;
    logic              out_end_reg;

    ncr_result_t       result;

    // the held item moves on whenever the result register is free or emptying
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_take    = in_valid && !in_stall;

    ncr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_advance),
        .char_code (s1_code_reg),
        .last      (s1_last_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || s1_advance)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_code_reg <= char_code;
            s1_last_reg <= last;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_code_reg     <= result.code;
            out_has_char_reg <= result.has_char;
            out_end_reg      <= result.end_of_text;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_code    = out_code_reg;
    assign has_char    = out_has_char_reg;
    assign end_of_text = out_end_reg;

endmodule

`default_nettype wire

// File: rtl/ncr_checker.sv
`default_nettype none

module ncr_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [ncr_pkg::CODE_W-1:0] out_code,
    input wire logic                       has_char,
    input wire logic                       end_of_text
);
    import ncr_pkg::*;

    // a stalled result transaction stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("output transaction withdrawn while stalled");

    // every result carries a character or marks the end of text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_char || end_of_text))
    else $error("empty output transaction");

    // an end marker without a character carries code zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> (out_code == '0))
    else $error("nonzero code on end marker without character");

    // with the result register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

    // an accepted input is never followed by a stall unless output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind numeric_char_reference_decoder ncr_checker u_ncr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_code    (out_code),
    .has_char    (has_char),
    .end_of_text (end_of_text)
);

`default_nettype wire
